[design/swm_pkg.sv]
// Shared types and constants for the sliding window median filter.
`timescale 1ns / 1ps

package swm_pkg;

    // Window geometry and field widths.
    localparam int WIN_MAX = 32;
    localparam int DATA_W  = 32;
    localparam int CNT_W   = $clog2(WIN_MAX + 1);
    localparam int IDX_W   = $clog2(WIN_MAX);
    localparam int AGE_W   = IDX_W;

    // Window length after reset.
    localparam logic [CNT_W-1:0] LEN_RESET = CNT_W'(5);

    // One slot of the sorted chain.
    typedef struct packed {
        logic              vld;
        logic [AGE_W-1:0]  age;
        logic [DATA_W-1:0] val;
    } cell_t;

    // Operation that every cell performs in a given cycle.
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_DELETE,
        OP_INSERT,
        OP_CLEAR
    } cell_op_t;

    // Control broadcast from the sequencer to the whole chain.
    typedef struct packed {
        cell_op_t          op;
        logic              full;
        logic [AGE_W-1:0]  old_age;
        logic [DATA_W-1:0] x;
    } cell_ctrl_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DELETE,
        ST_INSERT,
        ST_SELECT
    } seq_state_t;

endpackage

[design/swm_cell.sv]
// One cell of the sorted chain: holds a sample, its age and a valid flag.
`timescale 1ns / 1ps

module swm_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  swm_pkg::cell_ctrl_t ctrl,
    input  swm_pkg::cell_t     left_cell,
    input  logic               left_gt,
    input  swm_pkg::cell_t     right_cell,
    input  logic               hole_in,
    output swm_pkg::cell_t     cell_q,
    output logic               gt_out,
    output logic               hole_out
);
    import swm_pkg::*;

    cell_t cell_reg;
    cell_t cell_next;
    logic  kill;
    logic  take_left;
    logic  take_x;

    // This cell holds the oldest sample of a full window.
    assign kill     = cell_reg.vld && ctrl.full && (cell_reg.age == ctrl.old_age);
    assign hole_out = hole_in || kill;
    assign gt_out   = cell_reg.vld && (cell_reg.val > ctrl.x);

    // Insert decisions: cells above the new sample move up by one slot.
    assign take_left = left_gt;
    assign take_x    = !left_gt && (gt_out || !cell_reg.vld) && left_cell.vld;

    // Next content of the cell.
    always_comb
    begin
        cell_next = cell_reg;
        case (ctrl.op)
            OP_CLEAR:
            begin
                cell_next = '0;
            end
            OP_DELETE:
            begin
                if (hole_out)
                begin
                    cell_next = right_cell;
                end
            end
            OP_INSERT:
            begin
                if (take_left)
                begin
                    cell_next     = left_cell;
                    cell_next.age = left_cell.age + AGE_W'(1);
                end
                else if (take_x)
                begin
                    cell_next.vld = 1'b1;
                    cell_next.age = '0;
                    cell_next.val = ctrl.x;
                end
                else if (cell_reg.vld)
                begin
                    cell_next.age = cell_reg.age + AGE_W'(1);
                end
            end
            default:
            begin
                cell_next = cell_reg;
            end
        endcase
    end

    // Cell register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= '0;
        end
        else
        begin
            cell_reg <= cell_next;
        end
    end

    assign cell_q = cell_reg;

endmodule

[design/swm_chain.sv]
// Row of sorted cells with neighbor links and the rank read port.
`timescale 1ns / 1ps

module swm_chain (
    input  logic                         clk,
    input  logic                         rst_n,
    input  swm_pkg::cell_ctrl_t          ctrl,
    input  logic [swm_pkg::IDX_W-1:0]    sel_idx,
    output logic [swm_pkg::DATA_W-1:0]   sel_val
);
    import swm_pkg::*;

    cell_t cells_q [WIN_MAX];
    logic  gt      [WIN_MAX];
    logic  hole    [WIN_MAX+1];
    cell_t head_cell;

    // The slot left of the first cell looks occupied and never larger.
    always_comb
    begin
        head_cell     = '0;
        head_cell.vld = 1'b1;
    end

    assign hole[0] = 1'b0;

    // The cells, each linked to both neighbors.
    for (genvar i = 0; i < WIN_MAX; i++)
    begin : g_cell
        cell_t left_c;
        cell_t right_c;
        logic  left_g;

        if (i == 0)
        begin : g_first
            assign left_c = head_cell;
            assign left_g = 1'b0;
        end
        else
        begin : g_mid
            assign left_c = cells_q[i-1];
            assign left_g = gt[i-1];
        end

        if (i == WIN_MAX - 1)
        begin : g_last
            assign right_c = '0;
        end
        else
        begin : g_inner
            assign right_c = cells_q[i+1];
        end

        swm_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .left_cell  (left_c),
            .left_gt    (left_g),
            .right_cell (right_c),
            .hole_in    (hole[i]),
            .cell_q     (cells_q[i]),
            .gt_out     (gt[i]),
            .hole_out   (hole[i+1])
        );
    end

    // Value of the requested rank.
    assign sel_val = cells_q[sel_idx].val;

endmodule

[design/sliding_window_median_top.sv]
// Top level of the sliding window median filter: sequencer, registers and output stage.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+-------------------------------
//   input    | in_valid / in_stall         | sample[31:0]
//   output   | out_valid / out_stall       | median[31:0], samples_held[5:0]
//   config   | cfg_write_en                | cfg_write_data[5:0]
//
// An item passes through four steps: accept, removal of the oldest sample, sorted insert
// into the cell chain, and the rank read into the output register.
// The next transaction is accepted once the result is in the output register.
// Reset empties all cells and sets the window length to five.
// While the output is stalled with a result pending, a finished item waits in
// the read step and no new transaction is accepted.
`timescale 1ns / 1ps

module sliding_window_median_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [swm_pkg::DATA_W-1:0]  sample,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [swm_pkg::DATA_W-1:0]  median,
    output logic [swm_pkg::CNT_W-1:0]   samples_held,
    input  logic                        cfg_write_en,
    input  logic [swm_pkg::CNT_W-1:0]   cfg_write_data
);
    import swm_pkg::*;

    seq_state_t        state_reg;
    seq_state_t        state_next;
    logic [DATA_W-1:0] x_reg;
    logic [CNT_W-1:0]  len_reg;
    logic [CNT_W-1:0]  len_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [DATA_W-1:0] median_reg;
    logic [CNT_W-1:0]  held_reg;
    logic              load_out;
    logic              accept;
    logic              out_room;
    logic [CNT_W-1:0]  count_m1;
    logic [IDX_W-1:0]  sel_idx;
    logic [DATA_W-1:0] sel_val;
    logic [CNT_W-1:0]  len_m1;
    cell_ctrl_t        ctrl;

    // Handshake terms. A length write holds off the input in its cycle.
    assign in_stall = (state_reg != ST_IDLE) || cfg_write_en;
    assign accept   = in_valid && !in_stall;
    assign out_room = !out_valid_reg || !out_stall;

    // Rank of the median: (count - 1) / 2.
    assign count_m1 = count_reg - CNT_W'(1);
    assign sel_idx  = IDX_W'(count_m1 >> 1);
    assign len_m1   = len_reg - CNT_W'(1);

    // Sequencer: next state, chain control and counters.
    always_comb
    begin
        state_next   = state_reg;
        len_next     = len_reg;
        count_next   = count_reg;
        load_out     = 1'b0;
        ctrl.op      = OP_HOLD;
        ctrl.full    = (count_reg == len_reg);
        ctrl.old_age = AGE_W'(len_m1);
        ctrl.x       = x_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_write_en)
                begin
                    ctrl.op    = OP_CLEAR;
                    count_next = '0;
                    if (cfg_write_data == '0)
                    begin
                        len_next = CNT_W'(1);
                    end
                    else if (cfg_write_data > CNT_W'(WIN_MAX))
                    begin
                        len_next = CNT_W'(WIN_MAX);
                    end
                    else
                    begin
                        len_next = cfg_write_data;
                    end
                end
                else if (accept)
                begin
                    state_next = ST_DELETE;
                end
            end
            ST_DELETE:
            begin
                ctrl.op    = OP_DELETE;
                state_next = ST_INSERT;
                if (ctrl.full)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            ST_INSERT:
            begin
                ctrl.op    = OP_INSERT;
                count_next = count_reg + CNT_W'(1);
                state_next = ST_SELECT;
            end
            ST_SELECT:
            begin
                if (out_room)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid tracking.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= LEN_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg <= sample;
        end
        if (load_out)
        begin
            median_reg <= sel_val;
            held_reg   <= count_reg;
        end
    end

    // Sorted cell chain.
    swm_chain u_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .sel_idx (sel_idx),
        .sel_val (sel_val)
    );

    assign out_valid    = out_valid_reg;
    assign median       = median_reg;
    assign samples_held = held_reg;

`ifndef SYNTHESIS
    // The window never holds more samples than its length.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= len_reg)
        else $error("fill count exceeds window length");

    // The window length stays within its legal range.
    assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg >= CNT_W'(1)) && (len_reg <= CNT_W'(WIN_MAX)))
        else $error("window length out of range");

    // A removal pass is always followed by an insert pass.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DELETE |=> state_reg == ST_INSERT)
        else $error("insert pass did not follow removal pass");

    // A loaded result carries the fill count and is never empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> out_valid_reg && (held_reg == $past(count_reg))
                     && (held_reg != '0))
        else $error("result loaded with wrong fill count");
`endif

endmodule
